/* design/dual_stack_shared_buffer_assert.svh */
// Assertion macros for the dual stack buffer.
// CHK_ALWAYS: cond must hold at every clock edge outside reset.
// CHK_IMPLY: cons must hold in the cycle where ante holds.
// CHK_NEXT: cons must hold one cycle after ante holds.
`ifndef DUAL_STACK_SHARED_BUFFER_ASSERT_SVH
`define DUAL_STACK_SHARED_BUFFER_ASSERT_SVH

`ifndef SYNTH

`define CHK_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define CHK_ALWAYS(label, clk, rst, cond, msg)

`define CHK_IMPLY(label, clk, rst, ante, cons, msg)

`define CHK_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* design/dssb_pkg.sv */
package dssb_pkg;

   // pointer / count width, fixed by the capacity field
   localparam int PTR_W = 9;

   typedef logic [PTR_W-1:0] ptr_type;

   // operation codes
   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_POP   = 2'd1;
   localparam logic [1:0] OP_PEEK  = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   // status codes
   localparam logic [1:0] STS_OK    = 2'd0;
   localparam logic [1:0] STS_FULL  = 2'd1;
   localparam logic [1:0] STS_EMPTY = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic exec;   // execute the accepted operation
      logic load;   // move the result into the output register
   } cmd_type;

endpackage

/* design/dual_stack_shared_buffer.sv */
// Two LIFO stacks sharing one buffer of DEPTH entries, of which the first
// "capacity" are in use. The low stack grows up from entry 0, the high stack
// grows down from entry capacity-1; the buffer is full when their free ends
// meet. Each input transfer is one operation (push, pop, peek top, clear both)
// and yields exactly one output transfer carrying the read data (zero unless a
// pop or peek succeeded), a status (ok, full on refused push, empty on pop or
// peek of an empty stack), the total element count and all-empty / all-full
// flags. In the accept cycle the pointers move and the buffer is written or read
// into the registered buffer read port; the result then waits in the load state
// until the output register is free, and then enters it. A new item is taken
// only once the previous result has entered the output register; the next item
// is accepted while a finished result still waits in the output register.
// Writing capacity (clamped to 1..DEPTH) clears both stacks; write it only
// while no item is in flight. Buffer entries are not cleared at reset; only
// pushed entries are ever read back.
`include "dual_stack_shared_buffer_assert.svh"

module dual_stack_shared_buffer #(
   parameter int DEPTH      = 256,
   parameter int DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] push_value
   input  logic [2:0]  req_tuser,   // [1:0] operation, [2] which_stack (1 = low)
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [31:0] read_value, [40:32] element_count
   output logic [3:0]  rsp_tuser,   // [1:0] status, [2] all_empty, [3] all_full
   // capacity register
   input  logic        csr_we,
   input  logic [8:0]  csr_wdata
);

   dssb_pkg::cmd_type cmd;

   logic [31:0]       read_value;
   logic [1:0]        status;
   dssb_pkg::ptr_type element_count;
   logic              all_empty;
   logic              all_full;

   // FSM: paces the transfers, owns the output valid
   dssb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // pointers, buffer and result registers
   dssb_dp #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .operation     (req_tuser[1:0]),
      .which_stack   (req_tuser[2]),
      .push_value    (req_tdata),
      .read_value    (read_value),
      .status        (status),
      .element_count (element_count),
      .all_empty     (all_empty),
      .all_full      (all_full)
   );

   assign rsp_tdata = {7'b0, element_count, read_value};
   assign rsp_tuser = {all_full, all_empty, status};

   // an empty buffer can never be full (capacity is at least one)
   `CHK_IMPLY(a_empty_not_full, clock, reset, rsp_tvalid, !(all_empty && all_full), "empty and full together")
   // empty flag agrees with the count
   `CHK_IMPLY(a_empty_count, clock, reset, rsp_tvalid, all_empty == (element_count == '0), "empty flag vs count")
   // failed operations return no data
   `CHK_IMPLY(a_err_zero, clock, reset, rsp_tvalid && (status != dssb_pkg::STS_OK), read_value == '0, "data on error")
   // one item in flight: no accept in the cycle after an accept
   `CHK_NEXT(a_one_inflight, clock, reset, req_tvalid && req_tready, !req_tready, "back-to-back accept")

endmodule

/* design/dssb_ctrl.sv */
module dssb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output dssb_pkg::cmd_type cmd
);

   localparam logic [0:0] ST_IDLE = 1'b0;
   localparam logic [0:0] ST_LOAD = 1'b1;

   logic [0:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd.exec     = 1'b0;
      cmd.load     = 1'b0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.exec = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // wait for the output slot, read data is held meanwhile
            if (out_free) begin
               cmd.load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* design/dssb_dp.sv */
module dssb_dp #(
   parameter int DEPTH      = 256,
   parameter int DATA_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  dssb_pkg::cmd_type cmd,
   input  logic              csr_we,
   input  dssb_pkg::ptr_type csr_wdata,
   input  logic [1:0]        operation,
   input  logic              which_stack,
   input  logic [31:0]       push_value,
   output logic [31:0]       read_value,
   output logic [1:0]        status,
   output dssb_pkg::ptr_type element_count,
   output logic              all_empty,
   output logic              all_full
);

   localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PtrMax  = (1 << dssb_pkg::PTR_W) - 1;
   localparam int CapInt  = (DEPTH > PtrMax) ? PtrMax : DEPTH;
   localparam dssb_pkg::ptr_type CAP_MAX = dssb_pkg::PTR_W'(CapInt);
   localparam dssb_pkg::ptr_type ONE     = dssb_pkg::PTR_W'(1);

   logic [DATA_WIDTH-1:0] mem [DEPTH];

   dssb_pkg::ptr_type low_ff, low_in;
   dssb_pkg::ptr_type high_ff, high_in;
   dssb_pkg::ptr_type cap_ff, cap_in;

   // per-item result, captured at execute
   logic [1:0]            sts_ff, sts_in;
   dssb_pkg::ptr_type     cnt_ff, cnt_in;
   logic                  hit_ff, hit_in;
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // output register
   logic [31:0]       out_val_ff;
   logic [1:0]        out_sts_ff;
   dssb_pkg::ptr_type out_cnt_ff;
   logic              out_empty_ff;
   logic              out_full_ff;

   logic              wr_en;
   dssb_pkg::ptr_type wr_ptr;
   dssb_pkg::ptr_type rd_ptr;
   logic              is_full;
   logic              low_empty;
   logic              high_empty;

   assign is_full    = (low_ff >= high_ff);
   assign low_empty  = (low_ff == '0);
   assign high_empty = (high_ff >= cap_ff);

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      cap_in  = cap_ff;
      sts_in  = dssb_pkg::STS_OK;
      hit_in  = 1'b0;
      wr_en   = 1'b0;
      wr_ptr  = low_ff;
      rd_ptr  = low_ff - ONE;
      priority if (csr_we) begin
         // out-of-range capacity clamps to 1..DEPTH; a write clears both stacks
         if (csr_wdata == '0) begin
            cap_in = ONE;
         end else if (int'(csr_wdata) > DEPTH) begin
            cap_in = CAP_MAX;
         end else begin
            cap_in = csr_wdata;
         end
         low_in  = '0;
         high_in = cap_in;
      end else if (cmd.exec) begin
         unique case (operation)
            dssb_pkg::OP_PUSH: begin
               if (is_full) begin
                  sts_in = dssb_pkg::STS_FULL;
               end else if (which_stack) begin
                  wr_en  = 1'b1;
                  wr_ptr = low_ff;
                  low_in = low_ff + ONE;
               end else begin
                  wr_en   = 1'b1;
                  wr_ptr  = high_ff - ONE;
                  high_in = high_ff - ONE;
               end
            end
            dssb_pkg::OP_POP, dssb_pkg::OP_PEEK: begin
               if (which_stack) begin
                  rd_ptr = low_ff - ONE;
                  if (low_empty) begin
                     sts_in = dssb_pkg::STS_EMPTY;
                  end else begin
                     hit_in = 1'b1;
                     if (operation == dssb_pkg::OP_POP) begin
                        low_in = low_ff - ONE;
                     end
                  end
               end else begin
                  rd_ptr = high_ff;
                  if (high_empty) begin
                     sts_in = dssb_pkg::STS_EMPTY;
                  end else begin
                     hit_in = 1'b1;
                     if (operation == dssb_pkg::OP_POP) begin
                        high_in = high_ff + ONE;
                     end
                  end
               end
            end
            dssb_pkg::OP_CLEAR: begin
               low_in  = '0;
               high_in = cap_ff;
            end
            default: begin
               sts_in = dssb_pkg::STS_OK;
            end
         endcase
      end
      cnt_in = low_in + (cap_in - high_in);
   end

   // buffer: at most one write and one registered read per item
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[AW'(wr_ptr)] <= DATA_WIDTH'(push_value);
      end
      if (cmd.exec) begin
         rd_data_ff <= mem[AW'(rd_ptr)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= '0;
         high_ff <= CAP_MAX;
         cap_ff  <= CAP_MAX;
      end else begin
         low_ff  <= low_in;
         high_ff <= high_in;
         cap_ff  <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         sts_ff <= sts_in;
         cnt_ff <= cnt_in;
         hit_ff <= hit_in;
      end
      if (cmd.load) begin
         out_val_ff   <= hit_ff ? 32'(rd_data_ff) : '0;
         out_sts_ff   <= sts_ff;
         out_cnt_ff   <= cnt_ff;
         out_empty_ff <= (cnt_ff == '0);
         out_full_ff  <= (low_ff >= high_ff);
      end
   end

   assign read_value    = out_val_ff;
   assign status        = out_sts_ff;
   assign element_count = out_cnt_ff;
   assign all_empty     = out_empty_ff;
   assign all_full      = out_full_ff;

endmodule
